/* hw/rtl/sms_pkg.sv */
// Shared types and constants for the SMS concatenation segmenter.
// Holds the channel payload structs, the front-to-back job format and header codes.
// No dependencies.
package sms_pkg;

    localparam int DEF_SEGMENT_BYTES     = 132;
    localparam int DEF_MAX_MESSAGE_BYTES = 65535;
    localparam int QUEUE_DEPTH           = 4;

    // item kinds
    localparam logic KIND_START = 1'b0;
    localparam logic KIND_DATA  = 1'b1;

    // configuration register indexes
    localparam logic CFG_HEADER_MODE = 1'b0;
    localparam logic CFG_USE_PAYLOAD = 1'b1;

    // header modes; the unused code behaves as the 16-bit reference mode
    localparam logic [1:0] MODE_NONE  = 2'd0;
    localparam logic [1:0] MODE_REF8  = 2'd1;
    localparam logic [1:0] MODE_REF16 = 2'd2;

    // concatenation header bytes
    localparam logic [7:0] UDHL_REF8   = 8'h05;
    localparam logic [7:0] IEI_REF8    = 8'h00;
    localparam logic [7:0] IEDL_REF8   = 8'h03;
    localparam logic [7:0] UDHL_REF16  = 8'h06;
    localparam logic [7:0] IEI_REF16   = 8'h08;
    localparam logic [7:0] IEDL_REF16  = 8'h04;

    typedef struct packed {
        logic        kind;
        logic [15:0] message_length;
        logic [15:0] ref_number;
        logic [7:0]  data_byte;
    } t_in_item;

    typedef struct packed {
        logic [7:0]  out_byte;
        logic        is_header;
        logic [8:0]  segment_number;
        logic [8:0]  segment_total;
        logic [15:0] ref_out;
        logic [7:0]  segment_length;
        logic        udh_flag;
        logic        end_of_segment;
        logic        last_of_run;
    } t_out_item;

    // one classified data byte, ready for the back end
    typedef struct packed {
        logic [7:0]  data;
        logic        first;
        logic [8:0]  seq;
        logic [8:0]  total;
        logic [15:0] msg_ref;
        logic [7:0]  seglen;
        logic        eos;
    } t_job;

    typedef struct packed {
        logic valid;
        t_job job;
    } t_push;

    function automatic logic [2:0] header_len(input logic [1:0] mode);
        logic [2:0] len;
        case (mode)
            MODE_NONE: len = 3'd0;
            MODE_REF8: len = 3'd6;
            default:   len = 3'd7;
        endcase
        return len;
    endfunction

endpackage

/* hw/rtl/sms_front.sv */
// Front end: accepts start and data items, tracks message state, classifies bytes.
// Emits one job per live data byte into the queue. Uses sms_pkg.
module sms_front import sms_pkg::*; #(
    parameter int SEGMENT_BYTES     = DEF_SEGMENT_BYTES,
    parameter int MAX_MESSAGE_BYTES = DEF_MAX_MESSAGE_BYTES
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  t_in_item   i_in_data,
    input  logic       i_queue_full,
    input  logic [1:0] i_header_mode,
    input  logic       i_use_payload,
    output logic       o_in_stall,
    output t_push      o_push
);

    // ceil(len / SEGMENT_BYTES) by reciprocal multiply, exact for 17-bit dividends
    localparam int          DivShift = 25;
    localparam logic [25:0] RecipMul =
        26'(((64'd1 << DivShift) + 64'(SEGMENT_BYTES) - 64'd1) / 64'(SEGMENT_BYTES));

    logic [15:0] r_bytes_left, n_bytes_left;
    logic [15:0] r_ref, n_ref;
    logic [8:0]  r_total, n_total;
    logic [8:0]  r_seq, n_seq;
    logic [7:0]  r_pos, n_pos;
    logic        r_active, n_active;

    logic        w_accept;
    logic [15:0] w_len;
    logic [16:0] w_len_round;
    logic [42:0] w_prod;
    logic [16:0] w_sum;
    logic [7:0]  w_piece;
    logic [8:0]  w_seglen_full;
    logic [7:0]  w_seglen;
    logic        w_first;
    logic [8:0]  w_seq_next;
    logic [8:0]  w_pos_inc;
    logic [7:0]  w_pos_next;
    logic        w_eos;
    logic        w_live;

    assign w_accept   = i_in_valid && !i_queue_full;
    assign o_in_stall = i_queue_full;

    assign w_len       = (i_in_data.message_length > 16'(MAX_MESSAGE_BYTES))
                         ? 16'(MAX_MESSAGE_BYTES) : i_in_data.message_length;
    assign w_len_round = {1'b0, w_len} + 17'(SEGMENT_BYTES - 1);
    assign w_prod      = 43'(w_len_round) * 43'(RecipMul);

    assign w_sum   = {1'b0, r_bytes_left} + 17'(r_pos);
    assign w_piece = (w_sum > 17'(SEGMENT_BYTES)) ? 8'(SEGMENT_BYTES) : w_sum[7:0];
    assign w_seglen_full = {1'b0, w_piece} + 9'(header_len(i_header_mode));
    assign w_seglen = i_use_payload ? 8'd0
                    : (w_seglen_full > 9'd255 ? 8'hff : w_seglen_full[7:0]);

    assign w_first    = (r_pos == 8'd0);
    assign w_seq_next = w_first ? r_seq + 9'd1 : r_seq;
    assign w_pos_inc  = {1'b0, r_pos} + 9'd1;
    assign w_pos_next = (w_pos_inc[7:0] >= 8'(SEGMENT_BYTES)) ? 8'd0 : w_pos_inc[7:0];
    assign w_eos      = (w_pos_inc >= {1'b0, w_piece}) || (r_bytes_left == 16'd1);
    assign w_live     = r_active && (r_bytes_left != 16'd0);

    always_comb begin
        n_bytes_left = r_bytes_left;
        n_ref        = r_ref;
        n_total      = r_total;
        n_seq        = r_seq;
        n_pos        = r_pos;
        n_active     = r_active;
        if (w_accept) begin
            if (i_in_data.kind == KIND_START) begin
                // restart, dropping any message in progress
                n_bytes_left = w_len;
                n_ref        = i_in_data.ref_number;
                n_total      = w_prod[DivShift+8:DivShift];
                n_seq        = 9'd0;
                n_pos        = 8'd0;
                n_active     = (w_len != 16'd0);
            end else if (w_live) begin
                n_bytes_left = r_bytes_left - 16'd1;
                n_seq        = w_seq_next;
                n_pos        = w_pos_next;
                if (r_bytes_left == 16'd1) begin
                    n_active = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bytes_left <= '0;
            r_ref        <= '0;
            r_total      <= '0;
            r_seq        <= '0;
            r_pos        <= '0;
            r_active     <= 1'b0;
        end else begin
            r_bytes_left <= n_bytes_left;
            r_ref        <= n_ref;
            r_total      <= n_total;
            r_seq        <= n_seq;
            r_pos        <= n_pos;
            r_active     <= n_active;
        end
    end

    always_comb begin
        o_push.valid       = w_accept && (i_in_data.kind == KIND_DATA) && w_live;
        o_push.job.data    = i_in_data.data_byte;
        o_push.job.first   = w_first;
        o_push.job.seq     = w_seq_next;
        o_push.job.total   = r_total;
        o_push.job.msg_ref = r_ref;
        o_push.job.seglen  = w_seglen;
        o_push.job.eos     = w_eos;
    end

endmodule

/* hw/rtl/sms_queue.sv */
// Short job queue between the front and back ends.
// Register-based FIFO of QUEUE_DEPTH jobs; uses sms_pkg.
module sms_queue import sms_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_push i_push,
    input  logic  i_pop,
    output logic  o_full,
    output logic  o_empty,
    output t_job  o_head
);

    localparam int PtrW = $clog2(QUEUE_DEPTH);

    t_job            r_mem [QUEUE_DEPTH];
    logic [PtrW-1:0] r_wr_ptr;
    logic [PtrW-1:0] r_rd_ptr;
    logic [PtrW:0]   r_count;

    assign o_full  = (r_count == (PtrW+1)'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push.valid) begin
            r_mem[r_wr_ptr] <= i_push.job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push.valid) begin
                r_wr_ptr <= r_wr_ptr + PtrW'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + PtrW'(1);
            end
            case ({i_push.valid, i_pop})
                2'b10:   r_count <= r_count + (PtrW+1)'(1);
                2'b01:   r_count <= r_count - (PtrW+1)'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

/* hw/rtl/sms_back.sv */
// Back end: expands each job into its data byte, preceded by the header bytes on a segment's first job.
// Drives the output register; uses sms_pkg.
module sms_back import sms_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_job       i_head,
    input  logic       i_empty,
    input  logic [1:0] i_header_mode,
    input  logic       i_out_stall,
    output logic       o_pop,
    output logic       o_out_valid,
    output t_out_item  o_out_data
);

    function automatic logic [7:0] hdr_byte(input logic [1:0] mode, input logic [2:0] idx,
                                            input t_job job);
        logic [7:0] b;
        if (mode == MODE_REF8) begin
            case (idx)
                3'd0:    b = UDHL_REF8;
                3'd1:    b = IEI_REF8;
                3'd2:    b = IEDL_REF8;
                3'd3:    b = job.msg_ref[7:0];
                3'd4:    b = job.total[7:0];
                default: b = job.seq[7:0];
            endcase
        end else begin
            case (idx)
                3'd0:    b = UDHL_REF16;
                3'd1:    b = IEI_REF16;
                3'd2:    b = IEDL_REF16;
                3'd3:    b = job.msg_ref[15:8];
                3'd4:    b = job.msg_ref[7:0];
                3'd5:    b = job.total[7:0];
                default: b = job.seq[7:0];
            endcase
        end
        return b;
    endfunction

    logic [2:0] r_hidx;
    logic       r_out_valid;
    t_out_item  r_out;
    logic       w_load;
    logic       w_in_hdr;
    t_out_item  w_item;

    assign w_load   = !i_empty && (!r_out_valid || !i_out_stall);
    assign w_in_hdr = i_head.first && (r_hidx < header_len(i_header_mode));
    assign o_pop    = w_load && !w_in_hdr;

    always_comb begin
        w_item.out_byte       = w_in_hdr ? hdr_byte(i_header_mode, r_hidx, i_head)
                                         : i_head.data;
        w_item.is_header      = w_in_hdr;
        w_item.segment_number = i_head.seq;
        w_item.segment_total  = i_head.total;
        w_item.ref_out        = i_head.msg_ref;
        w_item.segment_length = i_head.seglen;
        w_item.udh_flag       = (i_header_mode != MODE_NONE);
        w_item.end_of_segment = !w_in_hdr && i_head.eos;
        w_item.last_of_run    = !w_in_hdr;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_hidx      <= '0;
        end else begin
            if (!r_out_valid || !i_out_stall) begin
                r_out_valid <= !i_empty;
            end
            if (w_load) begin
                r_hidx <= w_in_hdr ? r_hidx + 3'd1 : 3'd0;
            end
        end
    end

    // hold payload while stalled
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out <= w_item;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

/* hw/rtl/sms_concatenation_segmenter.sv */
// SMS concatenation segmenter top level: config registers, front, queue, back.
// Path: an accepted data byte is written into the queue and then into the output register;
// the first byte of a segment follows its 6 or 7 header results.
// Throughput: one input item per cycle if the queue has room, one result per cycle if not
// stalled; the 4-job queue hides short header bursts, but a long message stalls the input.
// Reset: synchronous active-low i_rst_n clears message state, queue and config.
module sms_concatenation_segmenter import sms_pkg::*; #(
    parameter int SEGMENT_BYTES     = DEF_SEGMENT_BYTES,
    parameter int MAX_MESSAGE_BYTES = DEF_MAX_MESSAGE_BYTES
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_cfg_we,
    input  logic      i_cfg_addr,
    input  logic [1:0] i_cfg_wdata,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_data
);

    logic [1:0] r_header_mode;
    logic       r_use_payload;
    t_push      w_push;
    logic       w_pop;
    logic       w_full;
    logic       w_empty;
    t_job       w_head;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_header_mode <= MODE_NONE;
            r_use_payload <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_HEADER_MODE: r_header_mode <= i_cfg_wdata;
                CFG_USE_PAYLOAD: r_use_payload <= i_cfg_wdata[0];
                default:         r_header_mode <= r_header_mode;
            endcase
        end
    end

    sms_front #(
        .SEGMENT_BYTES     (SEGMENT_BYTES),
        .MAX_MESSAGE_BYTES (MAX_MESSAGE_BYTES)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .i_in_data     (i_in_data),
        .i_queue_full  (w_full),
        .i_header_mode (r_header_mode),
        .i_use_payload (r_use_payload),
        .o_in_stall    (o_in_stall),
        .o_push        (w_push)
    );

    sms_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_pop   (w_pop),
        .o_full  (w_full),
        .o_empty (w_empty),
        .o_head  (w_head)
    );

    sms_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_head        (w_head),
        .i_empty       (w_empty),
        .i_header_mode (r_header_mode),
        .i_out_stall   (i_out_stall),
        .o_pop         (w_pop),
        .o_out_valid   (o_out_valid),
        .o_out_data    (o_out_data)
    );

    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_full |-> !w_push.valid)
        else $error("job pushed into a full queue");

    a_header_has_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.is_header) |->
            (o_out_data.udh_flag && !o_out_data.last_of_run))
        else $error("header byte without header flag or marked last");

    a_eos_on_data_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.end_of_segment) |-> o_out_data.last_of_run)
        else $error("end of segment on a non-data result");

    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> !w_empty)
        else $error("queue popped while empty");

endmodule

/* tb/sv/tb_top.sv */
// Testbench for sms_concatenation_segmenter: a directed start, then random message traffic.
// Holds a scoreboard class that predicts segment headers and bytes, plus the drivers.
// Depends on sms_pkg and the sms_concatenation_segmenter RTL.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import sms_pkg::*;

    localparam logic [1:0] MODE_SPARE = 2'd3;   // unused code, decodes as 16-bit reference
    localparam int DRAIN_CYCLES   = 8;
    localparam int HOLDOFF_CYCLES = 100;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int REPORT_LIMIT   = 100;

    class segment_scoreboard;
        logic [1:0]  hdr_mode;
        logic        payload_mode;
        logic [15:0] remaining;
        logic [15:0] msg_ref;
        logic [8:0]  seg_total;
        logic [8:0]  seg_seq;
        logic [7:0]  seg_pos;
        logic        active;
        t_out_item   expected_bytes[$];
        int          mismatches;
        int          results_checked;
        int          header_bytes;
        int          segment_ends;

        function new();
            hdr_mode        = MODE_NONE;
            payload_mode    = 1'b0;
            remaining       = '0;
            msg_ref         = '0;
            seg_total       = '0;
            seg_seq         = '0;
            seg_pos         = '0;
            active          = 1'b0;
            mismatches      = 0;
            results_checked = 0;
            header_bytes    = 0;
            segment_ends    = 0;
        endfunction

        function void configure(logic [1:0] mode, logic payload);
            hdr_mode     = mode;
            payload_mode = payload;
        endfunction

        function int pending();
            return expected_bytes.size();
        endfunction

        function void push_byte(logic [7:0] b, logic hdr, logic [7:0] seglen, logic eos,
                                logic last);
            t_out_item r;
            r.out_byte       = b;
            r.is_header      = hdr;
            r.segment_number = seg_seq;
            r.segment_total  = seg_total;
            r.ref_out        = msg_ref;
            r.segment_length = seglen;
            r.udh_flag       = (hdr_mode != MODE_NONE);
            r.end_of_segment = eos;
            r.last_of_run    = last;
            expected_bytes.push_back(r);
        endfunction

        function void note_input(t_in_item item);
            int unsigned count;
            int          hlen;
            int          piece;
            int          seglen;
            logic [7:0]  sl;
            logic        eos;
            if (item.kind == KIND_START) begin
                count     = (int'(item.message_length) + DEF_SEGMENT_BYTES - 1)
                            / DEF_SEGMENT_BYTES;
                remaining = item.message_length;
                msg_ref   = item.ref_number;
                seg_total = count[8:0];
                seg_seq   = '0;
                seg_pos   = '0;
                active    = (item.message_length != 0);
                return;
            end
            // drop bytes with no message open
            if (!active || remaining == 0)
                return;
            hlen  = (hdr_mode == MODE_NONE) ? 0 : ((hdr_mode == MODE_REF8) ? 6 : 7);
            piece = int'(remaining) + int'(seg_pos);
            if (piece > DEF_SEGMENT_BYTES)
                piece = DEF_SEGMENT_BYTES;
            seglen = payload_mode ? 0 : piece + hlen;
            if (seglen > 255)
                seglen = 255;
            sl = seglen[7:0];
            if (seg_pos == 0) begin
                seg_seq = seg_seq + 9'd1;
                if (hdr_mode == MODE_REF8) begin
                    push_byte(UDHL_REF8, 1'b1, sl, 1'b0, 1'b0);
                    push_byte(IEI_REF8, 1'b1, sl, 1'b0, 1'b0);
                    push_byte(IEDL_REF8, 1'b1, sl, 1'b0, 1'b0);
                    push_byte(msg_ref[7:0], 1'b1, sl, 1'b0, 1'b0);
                    push_byte(seg_total[7:0], 1'b1, sl, 1'b0, 1'b0);
                    push_byte(seg_seq[7:0], 1'b1, sl, 1'b0, 1'b0);
                end else if (hdr_mode != MODE_NONE) begin
                    push_byte(UDHL_REF16, 1'b1, sl, 1'b0, 1'b0);
                    push_byte(IEI_REF16, 1'b1, sl, 1'b0, 1'b0);
                    push_byte(IEDL_REF16, 1'b1, sl, 1'b0, 1'b0);
                    push_byte(msg_ref[15:8], 1'b1, sl, 1'b0, 1'b0);
                    push_byte(msg_ref[7:0], 1'b1, sl, 1'b0, 1'b0);
                    push_byte(seg_total[7:0], 1'b1, sl, 1'b0, 1'b0);
                    push_byte(seg_seq[7:0], 1'b1, sl, 1'b0, 1'b0);
                end
            end
            eos = (int'(seg_pos) + 1 >= piece) || (remaining == 16'd1);
            push_byte(item.data_byte, 1'b0, sl, eos, 1'b1);
            remaining = remaining - 16'd1;
            seg_pos   = seg_pos + 8'd1;
            if (int'(seg_pos) >= DEF_SEGMENT_BYTES)
                seg_pos = '0;
            if (remaining == 0)
                active = 1'b0;
        endfunction

        function void compare_field(string field, logic [15:0] want, logic [15:0] got);
            if (got !== want) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("%0t: %s mismatch: expected %0h, actual %0h",
                             $time, field, want, got);
                if (mismatches == REPORT_LIMIT)
                    $display("%0t: further mismatch reports suppressed", $time);
            end
        endfunction

        function void check_result(t_out_item got);
            t_out_item want;
            if (expected_bytes.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("%0t: unexpected result: expected none, actual %h",
                             $time, got);
                return;
            end
            want = expected_bytes.pop_front();
            results_checked++;
            if (want.is_header)
                header_bytes++;
            if (want.end_of_segment)
                segment_ends++;
            compare_field("out_byte", 16'(want.out_byte), 16'(got.out_byte));
            compare_field("is_header", 16'(want.is_header), 16'(got.is_header));
            compare_field("segment_number", 16'(want.segment_number),
                          16'(got.segment_number));
            compare_field("segment_total", 16'(want.segment_total), 16'(got.segment_total));
            compare_field("ref_out", want.ref_out, got.ref_out);
            compare_field("segment_length", 16'(want.segment_length),
                          16'(got.segment_length));
            compare_field("udh_flag", 16'(want.udh_flag), 16'(got.udh_flag));
            compare_field("end_of_segment", 16'(want.end_of_segment),
                          16'(got.end_of_segment));
            compare_field("last_of_run", 16'(want.last_of_run), 16'(got.last_of_run));
        endfunction
    endclass

    logic       i_clk = 1'b0;
    logic       i_rst_n;
    logic       i_cfg_we;
    logic       i_cfg_addr;
    logic [1:0] i_cfg_wdata;
    logic       i_in_valid;
    logic       o_in_stall;
    t_in_item   i_in_data;
    logic       o_out_valid;
    logic       i_out_stall;
    t_out_item  o_out_data;

    segment_scoreboard sb;
    int  burst_left = 0;
    bit  want_holdoff = 1'b0;
    int  holdoffs = 0;
    int  items_accepted = 0;
    int  input_stall_cycles = 0;
    int  idle_cycles = 0;
    int  settings_run = 0;

    sms_concatenation_segmenter DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // both channels are sampled at the edge that decides the transaction
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) begin
                sb.note_input(i_in_data);
                items_accepted++;
            end
            if (i_in_valid && o_in_stall)
                input_stall_cycles++;
            if (o_out_valid && !i_out_stall)
                sb.check_result(o_out_data);
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: no transaction for %0d cycles", $time, idle_cycles);
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    // receiver: stall patterns of random style and span, plus long hold-offs on request
    initial begin
        int  style;
        int  span;
        logic stall;
        i_out_stall <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n)
            @(posedge i_clk);
        forever begin
            if (want_holdoff) begin
                want_holdoff = 1'b0;
                holdoffs++;
                i_out_stall <= 1'b1;
                repeat (HOLDOFF_CYCLES) @(posedge i_clk);
            end else begin
                style = $urandom_range(0, 3);
                span  = $urandom_range(8, 40);
                for (int k = 0; k < span; k++) begin
                    case (style)
                        0: stall = 1'b0;
                        1: stall = 1'($urandom_range(0, 1));
                        2: stall = k[0];
                        default: stall = ($urandom_range(0, 3) == 0);
                    endcase
                    i_out_stall <= stall;
                    @(posedge i_clk);
                end
            end
        end
    end

    function automatic t_in_item rand_item(logic kind);
        t_in_item item;
        item.kind           = kind;
        item.message_length = 16'($urandom_range(0, 65535));
        item.ref_number     = 16'($urandom_range(0, 65535));
        item.data_byte      = 8'($urandom_range(0, 255));
        return item;
    endfunction

    // offer one transaction; the sender idles between bursts
    task automatic send_item(input t_in_item item);
        if (burst_left == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
            burst_left = $urandom_range(1, 40);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= item;
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
        burst_left--;
    endtask

    task automatic send_start(input logic [15:0] len, input logic [15:0] ref_num);
        t_in_item item;
        item                = rand_item(KIND_START);
        item.message_length = len;
        item.ref_number     = ref_num;
        send_item(item);
    endtask

    task automatic send_data(input logic [7:0] b);
        t_in_item item;
        item           = rand_item(KIND_DATA);
        item.data_byte = b;
        send_item(item);
    endtask

    task automatic send_message(input int len, input int n_bytes);
        send_start(len[15:0], 16'($urandom_range(0, 65535)));
        repeat (n_bytes) send_data(8'($urandom_range(0, 255)));
    endtask

    // hold the input low until every expected byte is out and the pipeline is quiet
    task automatic settle();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_config(input logic [1:0] mode, input logic payload);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= CFG_HEADER_MODE;
        i_cfg_wdata <= mode;
        @(posedge i_clk);
        i_cfg_addr  <= CFG_USE_PAYLOAD;
        i_cfg_wdata <= {1'b0, payload};
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        sb.configure(mode, payload);
        settings_run++;
    endtask

    // mostly complete messages, some cut short by a restart, some stray bytes
    task automatic random_traffic(input int n_items, input int long_len);
        int sent;
        int pick;
        int len;
        int n_bytes;
        sent = 0;
        if (long_len > 0) begin
            want_holdoff = 1'b1;
            send_message(long_len, long_len);
            sent += long_len + 1;
        end
        while (sent < n_items) begin
            pick = $urandom_range(0, 9);
            if (pick == 0) begin
                repeat ($urandom_range(1, 3)) send_item(rand_item(KIND_DATA));
            end else if (pick == 1) begin
                len     = $urandom_range(0, 65535);
                n_bytes = $urandom_range(0, 4);
                if (n_bytes > len)
                    n_bytes = len;
                send_message(len, n_bytes);
                sent += n_bytes + 1;
            end else if (pick == 2) begin
                send_message(0, 0);
                sent++;
            end else begin
                len = $urandom_range(1, 16);
                send_message(len, len);
                sent += len + 1;
            end
        end
    endtask

    task automatic run_phase(input logic [1:0] mode, input logic payload, input int n_items,
                             input int long_len);
        settle();
        set_config(mode, payload);
        random_traffic(n_items, long_len);
    endtask

    initial begin
        sb = new();
        i_rst_n     <= 1'b0;
        i_cfg_we    <= 1'b0;
        i_cfg_addr  <= CFG_HEADER_MODE;
        i_cfg_wdata <= MODE_NONE;
        i_in_valid  <= 1'b0;
        i_in_data   <= '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings: stray bytes, an empty message, extreme reference and bytes
        send_data(8'h3C);
        send_start(16'd0, 16'h0000);
        send_data(8'hC3);
        send_start(16'd3, 16'hFFFF);
        send_data(8'h00);
        send_data(8'hFF);
        send_data(8'hA5);

        // 8-bit header on the longest message, then a restart mid-message
        settle();
        set_config(MODE_REF8, 1'b0);
        send_start(16'hFFFF, 16'hABCD);
        send_data(8'h11);
        send_data(8'h22);
        send_start(16'd1, 16'h0001);
        send_data(8'h80);

        // spare mode code with payload-field reporting
        settle();
        set_config(MODE_SPARE, 1'b1);
        send_start(16'd2, 16'h1234);
        send_data(8'h01);
        send_data(8'hFE);

        settle();
        set_config(MODE_REF16, 1'b0);
        send_start(16'd4, 16'h8001);
        send_data(8'h5A);
        send_data(8'h96);
        send_start(16'd1, 16'h7FFE);
        send_data(8'h55);

        // one message long enough to open a second segment, under a receiver hold-off
        run_phase(MODE_NONE, 1'b1, 4, 0);
        run_phase(MODE_REF8, 1'b0, 0, $urandom_range(133, 134));
        run_phase(MODE_REF16, 1'b1, 4, 0);
        settle();

        if (sb.pending() != 0) begin
            sb.mismatches++;
            $display("%0t: %0d expected results never arrived", $time, sb.pending());
        end
        $display("Covered %0d input transactions over %0d register settings, %0d results",
                 items_accepted, settings_run, sb.results_checked);
        $display("with %0d header bytes, %0d segment ends, %0d hold-offs, %0d stalled cycles",
                 sb.header_bytes, sb.segment_ends, holdoffs, input_stall_cycles);
        if (sb.mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
